@@ rtl/pse_pkg.sv @@
// Shared opcodes, status codes and a helper for the postfix stack evaluator.
package pse_pkg;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_MOD    = 3'd5;
  localparam logic [2:0] OP_CONCAT = 3'd6;
  localparam logic [2:0] OP_END    = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_DIVZ  = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  // 10^(digit count of r), 10 for a negative r, wrapped to 32 bits
  function automatic logic [31:0] concat_scale(input logic [31:0] r);
    logic [31:0] s;
    s = 32'd10;
    if (!r[31]) begin
      if (r >= 32'd10)         s = 32'd100;
      if (r >= 32'd100)        s = 32'd1000;
      if (r >= 32'd1000)       s = 32'd10000;
      if (r >= 32'd10000)      s = 32'd100000;
      if (r >= 32'd100000)     s = 32'd1000000;
      if (r >= 32'd1000000)    s = 32'd10000000;
      if (r >= 32'd10000000)   s = 32'd100000000;
      if (r >= 32'd100000000)  s = 32'd1000000000;
      if (r >= 32'd1000000000) s = 32'd1410065408;
    end
    return s;
  endfunction

endpackage

@@ rtl/postfix_stack_evaluator.sv @@
// Postfix evaluator: stack held in a one-port-read synchronous memory.
// Steps: push is written from idle; add/sub pass RD_R, RD_L, CALC and PUSH;
// mul/concat add MUL, div/mod add DIV (32-step restoring divider); end token
// passes END to the result register. Tokens one at a time; input also waits while a result is stalled.
// Reset (rst_n low, synchronous) empties the stack and clears status;
// stack memory contents are not cleared.
module postfix_stack_evaluator import pse_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] opcode, [6:3] digit_value, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [33:32] status, [39:34] zero
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD_R = 4'd1;
  localparam logic [3:0] S_RD_L = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_PUSH = 4'd6;
  localparam logic [3:0] S_END  = 4'd7;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [2:0]    op_r, op_nxt;
  logic          rvalid_r, rvalid_nxt;   // the read register holds a valid popped word (low after an underflow)
  logic          lvalid_r, lvalid_nxt;
  logic [31:0]   right_r, right_nxt, left_r, left_nxt, res_r, res_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   rem_r, rem_nxt, quo_r, quo_nxt;
  logic [5:0]    step_r, step_nxt;
  logic          oval_r, oval_nxt;
  logic [33:0]   odata_r, odata_nxt;

  logic [2:0] in_op;
  logic [3:0] in_dig;
  assign in_op  = in_tdata[2:0];
  assign in_dig = in_tdata[6:3];

  logic [31:0] mag_l, mag_r, right_val;
  logic [32:0] trial;
  // the end token's popped word is still in the read register at S_END
  assign right_val = rvalid_r ? rd_data_r : 32'd0;
  assign mag_l = left_r[31]  ? (32'd0 - left_r)  : left_r;
  assign mag_r = right_r[31] ? (32'd0 - right_r) : right_r;
  assign trial = {rem_r, quo_r[31]} - {1'b0, mag_r};

  assign in_tready  = (state_r == S_IDLE) && !(oval_r && !out_tready);
  assign out_tvalid = oval_r;
  assign out_tdata  = {6'd0, odata_r};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    op_nxt     = op_r;
    rvalid_nxt = rvalid_r;
    lvalid_nxt = lvalid_r;
    right_nxt  = right_r;
    left_nxt   = left_r;
    res_nxt    = res_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    oval_nxt   = oval_r && !out_tready;
    odata_nxt  = odata_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = count_r[AW-1:0];
    wr_data    = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = in_op;
          if (in_op == OP_PUSH) begin
            if (count_r < CW'(STACK_DEPTH)) begin
              wr_en     = 1'b1;
              wr_data   = {28'd0, in_dig};
              count_nxt = count_r + 1'b1;
            end else if (err_r == ST_OK) begin
              err_nxt = ST_OVER;
            end
          end else begin
            // pop right: issue read of top entry
            if (count_r != '0) begin
              rd_en      = 1'b1;
              rd_addr    = AW'(count_r - 1'b1);
              count_nxt  = count_r - 1'b1;
              rvalid_nxt = 1'b1;
            end else begin
              rvalid_nxt = 1'b0;
              if (err_r == ST_OK) err_nxt = ST_UNDER;
            end
            state_nxt = (in_op == OP_END) ? S_END : S_RD_R;
          end
        end
      end
      S_RD_R: begin
        right_nxt = rvalid_r ? rd_data_r : 32'd0;
        rvalid_nxt = 1'b1;
        if (count_r != '0) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(count_r - 1'b1);
          count_nxt  = count_r - 1'b1;
          lvalid_nxt = 1'b1;
        end else begin
          lvalid_nxt = 1'b0;
          if (err_r == ST_OK) err_nxt = ST_UNDER;
        end
        state_nxt = S_RD_L;
      end
      S_RD_L: begin
        left_nxt   = lvalid_r ? rd_data_r : 32'd0;
        lvalid_nxt = 1'b1;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        case (op_r)
          OP_ADD: begin res_nxt = left_r + right_r; state_nxt = S_PUSH; end
          OP_SUB: begin res_nxt = left_r - right_r; state_nxt = S_PUSH; end
          OP_MUL: begin prod_nxt = left_r * right_r; state_nxt = S_MUL; end
          OP_CONCAT: begin
            prod_nxt  = left_r * concat_scale(right_r);
            state_nxt = S_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (right_r == 32'd0) begin
              res_nxt = 32'd0;
              if (err_r == ST_OK) err_nxt = ST_DIVZ;
              state_nxt = S_PUSH;
            end else begin
              rem_nxt   = 32'd0;
              quo_nxt   = mag_l;
              step_nxt  = 6'd0;
              state_nxt = S_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MUL: begin
        res_nxt   = (op_r == OP_CONCAT) ? prod_r + right_r : prod_r;
        state_nxt = S_PUSH;
      end
      S_DIV: begin
        // one restoring step per cycle; quotient shifts in where dividend shifts out
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 6'd31) begin
          state_nxt = S_PUSH;
        end else if (step_r == 6'd32) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (op_r == OP_DIV && step_r == 6'd32) begin
          wr_data = (left_r[31] != right_r[31]) ? (32'd0 - quo_r) : quo_r;
        end else if (op_r == OP_MOD && step_r == 6'd32) begin
          wr_data = left_r[31] ? (32'd0 - rem_r) : rem_r;
        end
        step_nxt = '0;
        if (count_r < CW'(STACK_DEPTH)) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end else if (err_r == ST_OK) begin
          err_nxt = ST_OVER;
        end
        state_nxt = S_IDLE;
      end
      S_END: begin
        oval_nxt   = 1'b1;
        odata_nxt  = {err_r, right_val};
        count_nxt  = '0;
        err_nxt    = ST_OK;
        rvalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      err_r    <= ST_OK;
      oval_r   <= 1'b0;
      rvalid_r <= 1'b1;
      lvalid_r <= 1'b1;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
      oval_r   <= oval_nxt;
      rvalid_r <= rvalid_nxt;
      lvalid_r <= lvalid_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    right_r <= right_nxt;
    left_r  <= left_nxt;
    res_r   <= res_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    odata_r <= odata_nxt;
  end

endmodule

@@ rtl/pse_checker.sv @@
// Port-level checker for the postfix stack evaluator, bound to the top level.
module pse_checker import pse_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  ap_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == 6'd0)
    else $error("result padding not zero");

  ap_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[2:0] != OP_PUSH |=> !in_tready)
    else $error("operator token not given time to complete");

  ap_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[2:0] == OP_END |=> ##1 out_tvalid)
    else $error("end token produced no result");

  ap_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ tb/sv/postfix_stack_evaluator_test.sv @@
// Self-checking testbench for the postfix stack evaluator: directed and random postfix streams.
`timescale 1ns / 1ps
module postfix_stack_evaluator_test;
  import pse_pkg::*;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;

  // opcode in the low bits, as on in_tdata
  typedef struct packed {
    logic [3:0] digit;
    logic [2:0] opcode;
  } token_t;

  // value in the low bits, as on out_tdata
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  token_t  token_q[$];
  answer_t answer_q[$];
  logic [31:0] eval_stack[DEPTH];
  int unsigned eval_count = 0;
  logic [1:0]  eval_err = ST_OK;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_off = 0;
  bit          stim_done = 1'b0;
  bit          drain_req = 1'b0;

  postfix_stack_evaluator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_err(logic [1:0] code);
    if (eval_err == ST_OK) eval_err = code;
  endfunction

  function automatic logic [31:0] pop_val();
    if (eval_count == 0) begin
      note_err(ST_UNDER);
      return '0;
    end
    eval_count--;
    return eval_stack[eval_count];
  endfunction

  function automatic void push_val(logic [31:0] w);
    if (eval_count < DEPTH) begin
      eval_stack[eval_count] = w;
      eval_count++;
    end else note_err(ST_OVER);
  endfunction

  function automatic logic [31:0] decimal_scale(logic [31:0] r);
    logic [31:0] s;
    s = 32'd10;
    if (!r[31]) begin
      while (r >= 32'd10) begin
        r = r / 32'd10;
        s = s * 32'd10;
      end
    end
    return s;
  endfunction

  // Advance the evaluator by one token, queue the answer on an end token.
  function automatic void evaluate(token_t t);
    logic [31:0] rhs, lhs, res, ma, mb;
    answer_t a;
    res = '0;
    if (t.opcode == OP_PUSH) begin
      push_val({28'd0, t.digit});
      return;
    end
    if (t.opcode == OP_END) begin
      a.value = pop_val();
      a.status = eval_err;
      answer_q.push_back(a);
      eval_count = 0;
      eval_err = ST_OK;
      return;
    end
    rhs = pop_val();
    lhs = pop_val();
    case (t.opcode)
      OP_ADD: res = lhs + rhs;
      OP_SUB: res = lhs - rhs;
      OP_MUL: res = lhs * rhs;
      OP_DIV, OP_MOD: begin
        if (rhs == 0) begin
          note_err(ST_DIVZ);
        end else begin
          ma = lhs[31] ? -lhs : lhs;
          mb = rhs[31] ? -rhs : rhs;
          if (t.opcode == OP_MOD) res = lhs[31] ? -(ma % mb) : ma % mb;
          else res = (lhs[31] != rhs[31]) ? -(ma / mb) : ma / mb;
        end
      end
      default: res = lhs * decimal_scale(rhs) + rhs;
    endcase
    push_val(res);
  endfunction

  function automatic void add_tok(logic [2:0] op, logic [3:0] d);
    token_t t;
    t.opcode = op;
    t.digit = d;
    token_q.push_back(t);
  endfunction

  function automatic logic [2:0] rand_op();
    case ($urandom_range(0, 5))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      3: return OP_DIV;
      4: return OP_MOD;
      default: return OP_CONCAT;
    endcase
  endfunction

  // Underflow-free expression with random content; may leave extra operands and build large values.
  function automatic void add_expression();
    int unsigned depth, n_ops, k;
    depth = 0;
    n_ops = $urandom_range(1, 8);
    k = 0;
    while (k < n_ops) begin
      if (depth < 2 || ($urandom_range(0, 2) == 0 && depth < 6)) begin
        add_tok(OP_PUSH, ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                     : 4'($urandom_range(0, 9)));
        depth++;
      end else begin
        add_tok(rand_op(), 4'($urandom));
        depth--;
        k++;
      end
    end
    add_tok(OP_END, 4'($urandom));
  endfunction

  initial begin
    int unsigned i;
    // Directed: every operator, digit extremes, error cases.
    add_tok(OP_PUSH, 4'd9); add_tok(OP_PUSH, 4'd15); add_tok(OP_ADD, 4'd0);
    add_tok(OP_PUSH, 4'd3); add_tok(OP_SUB, 4'd0); add_tok(OP_END, 4'd0);
    add_tok(OP_PUSH, 4'd7); add_tok(OP_PUSH, 4'd0); add_tok(OP_DIV, 4'd0);
    add_tok(OP_END, 4'd0);
    add_tok(OP_ADD, 4'd0); add_tok(OP_END, 4'd0);
    add_tok(OP_END, 4'd0);
    add_tok(OP_PUSH, 4'd0); add_tok(OP_PUSH, 4'd4); add_tok(OP_SUB, 4'd0);
    add_tok(OP_PUSH, 4'd3); add_tok(OP_MOD, 4'd0); add_tok(OP_PUSH, 4'd2);
    add_tok(OP_CONCAT, 4'd0); add_tok(OP_PUSH, 4'd5); add_tok(OP_MUL, 4'd0);
    add_tok(OP_END, 4'd0);
    // Overflow the stack.
    for (i = 0; i < DEPTH + 2; i++) add_tok(OP_PUSH, 4'($urandom));
    add_tok(OP_END, 4'd0);
    // INT_MIN div and mod by -1: 0-1 = -1, build 0x80000000 via 2^31.
    for (i = 0; i < 2; i++) begin
      add_tok(OP_PUSH, 4'd0); add_tok(OP_PUSH, 4'd2);
      repeat (29) begin add_tok(OP_PUSH, 4'd2); add_tok(OP_MUL, 4'd0); end
      add_tok(OP_PUSH, 4'd2); add_tok(OP_MUL, 4'd0);
      add_tok(OP_PUSH, 4'd0); add_tok(OP_PUSH, 4'd1); add_tok(OP_SUB, 4'd0);
      add_tok(i ? OP_MOD : OP_DIV, 4'd0); add_tok(OP_END, 4'd0);
    end
    // Big concat chain to reach large and negative values.
    add_tok(OP_PUSH, 4'd9);
    repeat (12) begin add_tok(OP_PUSH, 4'd9); add_tok(OP_CONCAT, 4'd0); end
    add_tok(OP_PUSH, 4'd0); add_tok(OP_PUSH, 4'd7); add_tok(OP_SUB, 4'd0);
    add_tok(OP_CONCAT, 4'd0); add_tok(OP_END, 4'd0);

    while (token_q.size() < 1250) begin
      if ($urandom_range(0, 9) < 8) add_expression();
      else add_tok(3'($urandom), 4'($urandom));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (token_q.size() < 700);
    drain_req = 1'b1;
    wait (token_q.size() == 0 && !in_tvalid);
    stim_done = 1'b1;
  end

  // Driver: bursts and gaps; one pause until all answers are back.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) evaluate(token_t'(in_tdata[6:0]));
      if (in_tvalid && !in_tready) begin
        // hold current transfer
      end else if (drain_req && answer_q.size() != 0) begin
        in_tvalid <= 1'b0;
      end else if (drain_req && hold_off < 60) begin
        in_tvalid <= 1'b0;
        hold_off <= hold_off + 1;
        if (hold_off == 59) drain_req = 1'b0;
      end else if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (token_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, token_q.pop_front()};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
        end else burst_left <= burst_left - 1;
      end else in_tvalid <= 1'b0;
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    answer_t got, exp_a;
    if (rst_n) begin
      out_tready <= ($urandom_range(0, 7) < 5) || (($urandom & 32'h3ff) < 200);
      if (out_tvalid && out_tready) begin
        got = answer_t'(out_tdata[33:0]);
        if (answer_q.size() == 0) begin
          $error("unexpected result value=%0d status=%0d", $signed(got.value), got.status);
          errors++;
        end else begin
          exp_a = answer_q.pop_front();
          if (got.value !== exp_a.value) begin
            $error("value: expected %0d, actual %0d", $signed(exp_a.value),
                   $signed(got.value));
            errors++;
          end
          if (got.status !== exp_a.status) begin
            $error("status: expected %0d, actual %0d", exp_a.status, got.status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (answer_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pse_pkg.sv
rtl/postfix_stack_evaluator.sv
rtl/pse_checker.sv
tb/sv/postfix_stack_evaluator_test.sv
